// ===== rtl/ilcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ilcm_pkg
// Shared widths, constants, register indexes and word types of the ink level
// and collision monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ilcm_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned THRESH_W   = 12;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned Z_W        = 16;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Ring entries start at this level after reset
  localparam logic [SAMPLE_W-1:0] RING_RESET = 12'd500;

  // Collision window on Z
  localparam logic signed [Z_W-1:0] Z_LOW_LIMIT  = -16'sd5;
  localparam logic signed [Z_W-1:0] Z_HIGH_LIMIT = 16'sd1;

  // Heartbeat follows this bit of the tick counter
  localparam int unsigned HEARTBEAT_BIT = 6;

  // Watch mode bits
  localparam int unsigned MODE_INK_BIT  = 0;
  localparam int unsigned MODE_COLL_BIT = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INK_TRIP   = 2'd0,
    CFG_WATCH_MODE = 2'd1
  } cfg_idx_e;

  // Input word
  typedef struct packed {
    logic [SAMPLE_W-1:0]   adc_sample;
    logic signed [Z_W-1:0] z_position;
    logic                  z_limit_closed;
    logic                  machine_in_cycle;
    logic                  clear_flags;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [SAMPLE_W-1:0] ink_mean;
    logic                low_ink;
    logic                collision_watch_active;
    logic                collision_error;
    logic                pause_requested;
    logic                indicator_led;
    logic                heartbeat_led;
  } out_word_t;

  // Per-word side data carried down the pipeline next to the sum
  typedef struct packed {
    logic signed [Z_W-1:0] z_position;
    logic                  z_limit_closed;
    logic                  machine_in_cycle;
    logic                  clear_flags;
    logic                  heartbeat;
  } side_t;

  // Configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/ilcm_ram.sv =====
// ----------------------------------------------------------------------------
// ilcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcm_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ilcm_window.sv =====
// ----------------------------------------------------------------------------
// ilcm_window
// Sample ring and running sum. The oldest sample is prefetched from the ring
// RAM so that each accepted word updates the sum in its accept cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcm_window #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        accept_i,
  input  wire logic [ilcm_pkg::SAMPLE_W-1:0]               sample_i,
  output      logic [ilcm_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum_o
);
  import ilcm_pkg::*;

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = SAMPLE_W + PTR_W;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(int'(RING_RESET) * WINDOW);

  logic [PTR_W-1:0]    ptr_q, ptr_nxt;
  logic [WINDOW-1:0]   vld_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] oldest;
  logic [PTR_W-1:0]    raddr;

  // Wrap the ring pointer at the window length
  assign ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

  // Prefetch the entry the next word will replace
  assign raddr = accept_i ? ptr_nxt : ptr_q;

  // Entries never written read as the reset level
  assign oldest = vld_q[ptr_q] ? ram_rdata : RING_RESET;
  assign sum_d  = sum_q - SUM_W'(oldest) + SUM_W'(sample_i);

  ilcm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (ptr_q),
    .wdata_i (sample_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Advance pointer, mark entry, update sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      vld_q <= '0;
      sum_q <= SUM_RESET;
    end else if (accept_i) begin
      ptr_q        <= ptr_nxt;
      vld_q[ptr_q] <= 1'b1;
      sum_q        <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/ilcm_mean.sv =====
// ----------------------------------------------------------------------------
// ilcm_mean
// Mean stage: divides the running sum by the window length through an exact
// reciprocal multiply, registered, and carries the side data along.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcm_mean #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        en_i,
  input  wire logic                                        vld_i,
  input  wire logic [ilcm_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum_i,
  input  wire ilcm_pkg::side_t                             side_i,
  output      logic                                        vld_o,
  output      logic [ilcm_pkg::SAMPLE_W-1:0]               mean_o,
  output      ilcm_pkg::side_t                             side_o
);
  import ilcm_pkg::*;

  localparam int unsigned LOG_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_W + LOG_W;
  localparam int unsigned SHIFT  = SUM_W + LOG_W;
  localparam int unsigned MUL_W  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  // Rounded-up reciprocal; exact for every sum below WINDOW * 2^SAMPLE_W
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

  logic [PROD_W-1:0] prod_q;
  side_t             side_q;
  logic              vld_q;

  // Multiply and hold the product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(RECIP_C);
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  assign vld_o  = vld_q;
  assign mean_o = prod_q[SHIFT +: SAMPLE_W];
  assign side_o = side_q;

endmodule

`default_nettype wire

// ===== rtl/ilcm_flags.sv =====
// ----------------------------------------------------------------------------
// ilcm_flags
// Configuration registers, low-ink and collision watches, the two latches
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcm_flags (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ilcm_pkg::cfg_wr_t             cfg_i,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic [ilcm_pkg::SAMPLE_W-1:0] mean_i,
  input  wire ilcm_pkg::side_t               side_i,
  output      logic                          out_valid_o,
  output      ilcm_pkg::out_word_t           out_word_o
);
  import ilcm_pkg::*;

  logic [THRESH_W-1:0] thresh_q;
  logic [MODE_W-1:0]   mode_q;
  logic                pause_q, pause_d;
  logic                coll_q, coll_d;
  logic                low_ink;
  logic                watch;
  logic                hit;
  logic                out_vld_q;
  out_word_t           out_word_q, out_word_d;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
      mode_q   <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_INK_TRIP:   thresh_q <= cfg_i.wdata[THRESH_W-1:0];
        CFG_WATCH_MODE: mode_q   <= cfg_i.wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Watch conditions
  assign low_ink = mode_q[MODE_INK_BIT] && (mean_i < thresh_q);
  assign watch   = mode_q[MODE_COLL_BIT] && side_i.machine_in_cycle;
  assign hit     = watch &&
                   (((side_i.z_position <= Z_LOW_LIMIT) && !side_i.z_limit_closed) ||
                    ((side_i.z_position > Z_HIGH_LIMIT) && side_i.z_limit_closed));

  // Clear first, then set
  assign pause_d = (pause_q && !side_i.clear_flags) || low_ink;
  assign coll_d  = (coll_q && !side_i.clear_flags) || hit;

  always_comb begin
    out_word_d.ink_mean               = mean_i;
    out_word_d.low_ink                = low_ink;
    out_word_d.collision_watch_active = watch;
    out_word_d.collision_error        = coll_d;
    out_word_d.pause_requested        = pause_d;
    out_word_d.indicator_led          = low_ink || watch;
    out_word_d.heartbeat_led          = side_i.heartbeat;
  end

  // Latch updates and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q   <= 1'b0;
      coll_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_i;
      if (vld_i) begin
        pause_q <= pause_d;
        coll_q  <= coll_d;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/ink_level_collision_monitor_top.sv =====
// ----------------------------------------------------------------------------
// ink_level_collision_monitor_top
// Boxcar average of ink sensor samples with a low-ink threshold, Z collision
// watch with latched flags, and a heartbeat LED.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_word_i   (in_word_t)
//   out      output     out_valid_o / out_stall_i out_word_o  (out_word_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while no result is stalled; each accepted word
// passes the sum update, reciprocal multiply and flag/result register in turn.
// The ring RAM read is prefetched one word ahead, so the sum updates in the
// accept cycle. Ring entries never written read as 500 through valid bits
// cleared at reset; no clearing pass is needed.
// A stalled result holds the whole pipeline; in_stall_o rises only while a
// result waits on out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module ink_level_collision_monitor_top #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire ilcm_pkg::in_word_t              in_word_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      ilcm_pkg::out_word_t             out_word_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ilcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ilcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ilcm_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);

  logic                advance;
  logic                accept;
  logic [TICK_W-1:0]   tick_q;
  side_t               side_in, side_s1_q, side_s2;
  logic                s1_vld_q, s2_vld;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] mean;
  cfg_wr_t             cfg;

  // Move the pipeline unless a result waits
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  always_comb begin
    side_in.z_position       = in_word_i.z_position;
    side_in.z_limit_closed   = in_word_i.z_limit_closed;
    side_in.machine_in_cycle = in_word_i.machine_in_cycle;
    side_in.clear_flags      = in_word_i.clear_flags;
    side_in.heartbeat        = tick_q[HEARTBEAT_BIT];
  end

  // Advance tick counter per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_valid_i;
      if (in_valid_i) begin
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  // Hold side data next to the updated sum
  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_s1_q <= side_in;
    end
  end

  ilcm_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_word_i.adc_sample),
    .sum_o    (sum)
  );

  ilcm_mean #(
    .WINDOW (WINDOW)
  ) u_mean (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .vld_i  (s1_vld_q),
    .sum_i  (sum),
    .side_i (side_s1_q),
    .vld_o  (s2_vld),
    .mean_o (mean),
    .side_o (side_s2)
  );

  ilcm_flags u_flags (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .en_i        (advance),
    .vld_i       (s2_vld),
    .mean_i      (mean),
    .side_i      (side_s2),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ilcm_checker.sv =====
// ----------------------------------------------------------------------------
// ilcm_checker
// Port-level checks of the monitor: stall behavior, held results, and
// watch flags against the configured watch mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire ilcm_pkg::out_word_t             out_word_o,
  input wire logic                            cfg_we_i,
  input wire logic [ilcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [ilcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ilcm_pkg::*;

  logic [MODE_W-1:0] mode_q;

  // Track the watch mode register from port writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_WATCH_MODE)) begin
      mode_q <= cfg_wdata_i[MODE_W-1:0];
    end
  end

  // Input is never held off while no result waits
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

  // A stalled result stays and does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  // Low ink only with the low-ink watch enabled
  a_low_ink_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.low_ink |-> mode_q[MODE_INK_BIT])
    else $error("low ink flagged with watch disabled");

  // Collision watch only with the collision watch enabled
  a_coll_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.collision_watch_active |-> mode_q[MODE_COLL_BIT])
    else $error("collision watch active with watch disabled");

endmodule

bind ink_level_collision_monitor_top ilcm_checker u_ilcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

`default_nettype wire
